// ===== sv/ftm_pkg.sv =====
// ----------------------------------------------------------------------------
// ftm_pkg
// Shared types and constants of the follower tier mode selector: tier and
// reason codes, register indexes, the input item and the configuration set.
// ----------------------------------------------------------------------------
package ftm_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned RATIO_W     = 12;
   localparam int unsigned DIST_W      = 16;
   localparam int unsigned MS_W        = 32;
   localparam int unsigned TICK_W      = 16;

   localparam logic [TICK_W-1:0] DEFAULT_TICK_MS = TICK_W'(100);

   typedef enum logic [2:0] {
      TIER_PRED    = 3'd0,
      TIER_NORMAL  = 3'd1,
      TIER_REROUTE = 3'd2,
      TIER_CATCH   = 3'd3,
      TIER_HARD    = 3'd4,
      TIER_CRUMB   = 3'd5
   } tier_type;

   typedef enum logic [3:0] {
      RS_OBSTACLE = 4'd0,
      RS_CLEARED  = 4'd1,
      RS_TIMEOUT  = 4'd2,
      RS_FAR      = 4'd3,
      RS_HARD     = 4'd4,
      RS_CATCHUP  = 4'd5,
      RS_LOST     = 4'd6,
      RS_RESTORED = 4'd7,
      RS_RECEIVED = 4'd8
   } reason_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HYSTERESIS   = 3'd0,
      CSR_CHASE        = 3'd1,
      CSR_HARD_CATCH   = 3'd2,
      CSR_BREADCRUMB   = 3'd3,
      CSR_COMM_TIMEOUT = 3'd4,
      CSR_REROUTE_MIN  = 3'd5
   } csr_index_type;

   localparam logic [RATIO_W-1:0] RST_HYSTERESIS   = RATIO_W'(26);
   localparam logic [RATIO_W-1:0] RST_CHASE        = RATIO_W'(384);
   localparam logic [RATIO_W-1:0] RST_HARD_CATCH   = RATIO_W'(512);
   localparam logic [RATIO_W-1:0] RST_BREADCRUMB   = RATIO_W'(1024);
   localparam logic [MS_W-1:0]    RST_COMM_TIMEOUT = MS_W'(60000);
   localparam logic [MS_W-1:0]    RST_REROUTE_MIN  = MS_W'(1000);

   typedef struct packed {
      logic [RATIO_W-1:0] hyst_q8;
      logic [RATIO_W-1:0] chase_q8;
      logic [RATIO_W-1:0] sprint_q8;
      logic [RATIO_W-1:0] trail_q8;
      logic [MS_W-1:0]    link_timeout_ms;
      logic [MS_W-1:0]    reroute_min_dwell_ms;
   } cfg_type;

   typedef struct packed {
      logic              obstacle_present;
      logic [DIST_W-1:0] gap_cm;
      logic [DIST_W-1:0] base_distance_cm;
      logic [MS_W-1:0]   loss_time_ms;
      logic              prediction_fresh;
      logic              link_alive;
      logic [TICK_W-1:0] tick_ms;
   } req_type;

endpackage

// ===== sv/ftm_if.sv =====
// ----------------------------------------------------------------------------
// ftm_req_if / ftm_rsp_if
// Valid/ready channels carrying one input item and one result item.
// ----------------------------------------------------------------------------
interface ftm_req_if;
   logic        valid;
   logic        ready;
   logic        obstacle_present;
   logic [15:0] gap_cm;
   logic [15:0] base_distance_cm;
   logic [31:0] loss_time_ms;
   logic        prediction_fresh;
   logic        link_alive;
   logic [15:0] tick_ms;

   modport source (output valid, obstacle_present, gap_cm, base_distance_cm, loss_time_ms,
                   prediction_fresh, link_alive, tick_ms, input ready);
   modport sink (input valid, obstacle_present, gap_cm, base_distance_cm, loss_time_ms,
                 prediction_fresh, link_alive, tick_ms, output ready);
endinterface

interface ftm_rsp_if;
   logic       valid;
   logic       ready;
   logic       changed;
   logic [2:0] tier_now;
   logic [3:0] reason_code;

   modport source (output valid, changed, tier_now, reason_code, input ready);
   modport sink (input valid, changed, tier_now, reason_code, output ready);
endinterface

// ===== sv/ftm_gap_cmp.sv =====
// ----------------------------------------------------------------------------
// ftm_gap_cmp
// Signed compare of gap * 256 against base distance times a Q4.8 ratio,
// with the hysteresis ratio taken off while already in the tier.
// ----------------------------------------------------------------------------
module ftm_gap_cmp import ftm_pkg::*; (
   input  logic [DIST_W-1:0]  gap_cm,
   input  logic [DIST_W-1:0]  base_distance_cm,
   input  logic [RATIO_W-1:0] ratio,
   input  logic [RATIO_W-1:0] hyst_q8,
   input  logic               own_tier,
   output logic               exceeds
);

   logic signed [RATIO_W:0]          ratio_adj;
   logic signed [DIST_W+RATIO_W+1:0] threshold;
   logic signed [DIST_W+RATIO_W+1:0] gap_scaled;

   assign ratio_adj  = $signed({1'b0, ratio})
                       - (own_tier ? $signed({1'b0, hyst_q8}) : $signed((RATIO_W+1)'(0)));
   assign threshold  = $signed({1'b0, base_distance_cm}) * ratio_adj;
   assign gap_scaled = $signed({(RATIO_W-6)'(0), gap_cm, 8'b0});
   assign exceeds    = gap_scaled > threshold;

endmodule

// ===== sv/ftm_tier_core.sv =====
// ----------------------------------------------------------------------------
// ftm_tier_core
// Tier decision, dwell bookkeeping and the result register. One registered
// item is resolved per cycle whenever the result register can take it.
// ----------------------------------------------------------------------------
module ftm_tier_core import ftm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       item_valid,
   input  req_type    item,
   output logic       item_take,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_changed,
   output logic [2:0] rsp_tier_now,
   output logic [3:0] rsp_reason_code
);

   tier_type        tier_ff, tier_in;
   reason_type      reason_ff, reason_in;
   logic [MS_W-1:0] dwell_ff, dwell_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            changed_ff, changed_in;

   logic            crumb_hit, hard_hit, catch_hit, timeout;
   tier_type        desired;
   logic [TICK_W-1:0] step_ms;
   logic [MS_W:0]   dwell_sum;
   logic [MS_W-1:0] dwell_adv;
   logic            hold_reroute;
   reason_type      reason_new;

   ftm_gap_cmp u_cmp_crumb (
      .gap_cm(item.gap_cm), .base_distance_cm(item.base_distance_cm),
      .ratio(cfg.trail_q8), .hyst_q8(cfg.hyst_q8),
      .own_tier(tier_ff == TIER_CRUMB), .exceeds(crumb_hit)
   );

   ftm_gap_cmp u_cmp_hard (
      .gap_cm(item.gap_cm), .base_distance_cm(item.base_distance_cm),
      .ratio(cfg.sprint_q8), .hyst_q8(cfg.hyst_q8),
      .own_tier(tier_ff == TIER_HARD), .exceeds(hard_hit)
   );

   ftm_gap_cmp u_cmp_catch (
      .gap_cm(item.gap_cm), .base_distance_cm(item.base_distance_cm),
      .ratio(cfg.chase_q8), .hyst_q8(cfg.hyst_q8),
      .own_tier(tier_ff == TIER_CATCH), .exceeds(catch_hit)
   );

   assign item_take = item_valid && (!rsp_valid_ff || rsp_ready);
   assign timeout   = item.loss_time_ms > cfg.link_timeout_ms;
   assign step_ms   = (item.tick_ms == '0) ? DEFAULT_TICK_MS : item.tick_ms;
   assign dwell_sum = {1'b0, dwell_ff} + {(MS_W+1-TICK_W)'(0), step_ms};
   assign dwell_adv = dwell_sum[MS_W] ? '1 : dwell_sum[MS_W-1:0];

   always_comb begin
      if (item.obstacle_present) begin
         desired = TIER_REROUTE;
      end else if (crumb_hit || timeout) begin
         desired = TIER_CRUMB;
      end else if (hard_hit) begin
         desired = TIER_HARD;
      end else if (catch_hit) begin
         desired = TIER_CATCH;
      end else if (item.prediction_fresh) begin
         desired = TIER_PRED;
      end else if (item.link_alive) begin
         desired = TIER_NORMAL;
      end else begin
         desired = TIER_CRUMB;
      end
   end

   always_comb begin
      if (desired == TIER_REROUTE) begin
         reason_new = RS_OBSTACLE;
      end else if (tier_ff == TIER_REROUTE) begin
         reason_new = RS_CLEARED;
      end else begin
         case (desired)
            TIER_CRUMB:  reason_new = timeout ? RS_TIMEOUT : RS_FAR;
            TIER_HARD:   reason_new = RS_HARD;
            TIER_CATCH:  reason_new = RS_CATCHUP;
            TIER_NORMAL: reason_new = RS_LOST;
            default:     reason_new = (tier_ff == TIER_CRUMB) ? RS_RESTORED : RS_RECEIVED;
         endcase
      end
   end

   assign hold_reroute = (tier_ff == TIER_REROUTE) && (desired != TIER_REROUTE)
                         && (dwell_ff < cfg.reroute_min_dwell_ms);

   always_comb begin
      tier_in      = tier_ff;
      reason_in    = reason_ff;
      dwell_in     = dwell_ff;
      changed_in   = changed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (item_take) begin
         rsp_valid_in = 1'b1;
         if (hold_reroute || desired == tier_ff) begin
            dwell_in   = dwell_adv;
            changed_in = 1'b0;
         end else begin
            tier_in    = desired;
            reason_in  = reason_new;
            dwell_in   = '0;
            changed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tier_ff      <= TIER_NORMAL;
         reason_ff    <= RS_OBSTACLE;
         dwell_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tier_ff      <= tier_in;
         reason_ff    <= reason_in;
         dwell_ff     <= dwell_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   logic [2:0] rsp_tier_ff;
   logic [3:0] rsp_reason_ff;

   always_ff @(posedge clock) begin
      changed_ff <= changed_in;
      if (item_take) begin
         rsp_tier_ff   <= tier_in;
         rsp_reason_ff <= reason_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_changed     = changed_ff;
   assign rsp_tier_now    = rsp_tier_ff;
   assign rsp_reason_code = rsp_reason_ff;

endmodule

// ===== sv/follower_tier_mode_fsm_core.sv =====
// ----------------------------------------------------------------------------
// follower_tier_mode_fsm_core
// Follower tier selector: picks a tier per control tick with hysteresis on
// gap thresholds and a minimum dwell in reroute, and reports the reason.
// Each accepted item is held in the input register, then resolved into the result register once it can take it.
// Throughput: one item per cycle while the result receiver is not stalling, set by the tier update.
// Reset (synchronous): normal tier, dwell 0, reason 0, registers to defaults.
// ----------------------------------------------------------------------------
module follower_tier_mode_fsm_core import ftm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   ftm_req_if.sink                req_chan,
   ftm_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    item_take;
   logic    req_accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_HYSTERESIS:   cfg_in.hyst_q8              = csr_wdata[RATIO_W-1:0];
            CSR_CHASE:        cfg_in.chase_q8             = csr_wdata[RATIO_W-1:0];
            CSR_HARD_CATCH:   cfg_in.sprint_q8            = csr_wdata[RATIO_W-1:0];
            CSR_BREADCRUMB:   cfg_in.trail_q8             = csr_wdata[RATIO_W-1:0];
            CSR_COMM_TIMEOUT: cfg_in.link_timeout_ms      = csr_wdata[MS_W-1:0];
            CSR_REROUTE_MIN:  cfg_in.reroute_min_dwell_ms = csr_wdata[MS_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hyst_q8              <= RST_HYSTERESIS;
         cfg_ff.chase_q8             <= RST_CHASE;
         cfg_ff.sprint_q8            <= RST_HARD_CATCH;
         cfg_ff.trail_q8             <= RST_BREADCRUMB;
         cfg_ff.link_timeout_ms      <= RST_COMM_TIMEOUT;
         cfg_ff.reroute_min_dwell_ms <= RST_REROUTE_MIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_chan.ready = !in_valid_ff || item_take;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_accept || (in_valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.obstacle_present <= req_chan.obstacle_present;
         in_item_ff.gap_cm           <= req_chan.gap_cm;
         in_item_ff.base_distance_cm <= req_chan.base_distance_cm;
         in_item_ff.loss_time_ms     <= req_chan.loss_time_ms;
         in_item_ff.prediction_fresh <= req_chan.prediction_fresh;
         in_item_ff.link_alive       <= req_chan.link_alive;
         in_item_ff.tick_ms          <= req_chan.tick_ms;
      end
   end

   ftm_tier_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .item_valid      (in_valid_ff),
      .item            (in_item_ff),
      .item_take       (item_take),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_changed     (rsp_chan.changed),
      .rsp_tier_now    (rsp_chan.tier_now),
      .rsp_reason_code (rsp_chan.reason_code)
   );

endmodule

// ===== test/follower_tier_mode_fsm_core_tb.sv =====
// ----------------------------------------------------------------------------
// follower_tier_mode_fsm_core_tb
// Drives control ticks into the follower tier selector and checks each tier
// report against a cycle-free predictor of tier choice, hysteresis, reroute
// dwell hold, saturating dwell time and reason codes. Runs several register
// settings, extremes among them, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module follower_tier_mode_fsm_core_tb;
   import ftm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [TICK_W-1:0]      TICK_MAX     = '1;

   typedef struct packed {
      logic       changed;
      tier_type   tier;
      reason_type reason;
   } tier_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ftm_req_if req_if ();
   ftm_rsp_if rsp_if ();

   follower_tier_mode_fsm_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   cfg_type         tier_cfg = '{RST_HYSTERESIS, RST_CHASE, RST_HARD_CATCH, RST_BREADCRUMB,
                                 RST_COMM_TIMEOUT, RST_REROUTE_MIN};
   tier_type        tier_state = TIER_NORMAL;
   logic [31:0]     dwell_ms = '0;
   reason_type      reason_state = RS_OBSTACLE;
   req_type         pending_ticks_q[$];
   tier_report_type tier_reports_q[$];
   int unsigned     mismatch_count = 0;
   int unsigned     burst_left = 0;
   int unsigned     gap_left = 0;
   int unsigned     stall_mode = 0;
   int unsigned     stall_span = 0;
   int unsigned     stall_phase = 0;

   function automatic logic over_threshold(input logic [DIST_W-1:0] gap,
                                           input logic [DIST_W-1:0] base,
                                           input logic [RATIO_W-1:0] ratio,
                                           input logic own);
      longint span;
      span = longint'(ratio) - (own ? longint'(tier_cfg.hyst_q8) : longint'(0));
      return longint'(gap) * 256 > longint'(base) * span;
   endfunction

   function automatic void predict_tier(input req_type it);
      tier_type        want;
      reason_type      why;
      logic            lapsed;
      logic [31:0]     step;
      logic [32:0]     sum;
      tier_report_type report;
      step = (it.tick_ms == '0) ? 32'(DEFAULT_TICK_MS) : 32'(it.tick_ms);
      lapsed = it.loss_time_ms > tier_cfg.link_timeout_ms;
      if (it.obstacle_present) begin
         want = TIER_REROUTE;
      end else if (over_threshold(it.gap_cm, it.base_distance_cm, tier_cfg.trail_q8,
                                  tier_state == TIER_CRUMB) || lapsed) begin
         want = TIER_CRUMB;
      end else if (over_threshold(it.gap_cm, it.base_distance_cm, tier_cfg.sprint_q8,
                                  tier_state == TIER_HARD)) begin
         want = TIER_HARD;
      end else if (over_threshold(it.gap_cm, it.base_distance_cm, tier_cfg.chase_q8,
                                  tier_state == TIER_CATCH)) begin
         want = TIER_CATCH;
      end else if (it.prediction_fresh) begin
         want = TIER_PRED;
      end else if (it.link_alive) begin
         want = TIER_NORMAL;
      end else begin
         want = TIER_CRUMB;
      end

      report.changed = 1'b0;
      if ((tier_state == TIER_REROUTE && want != TIER_REROUTE &&
           dwell_ms < tier_cfg.reroute_min_dwell_ms) || want == tier_state) begin
         sum = {1'b0, dwell_ms} + {1'b0, step};
         dwell_ms = sum[32] ? '1 : sum[31:0];
      end else begin
         if (want == TIER_REROUTE) begin
            why = RS_OBSTACLE;
         end else if (tier_state == TIER_REROUTE) begin
            why = RS_CLEARED;
         end else if (want == TIER_CRUMB) begin
            why = lapsed ? RS_TIMEOUT : RS_FAR;
         end else if (want == TIER_HARD) begin
            why = RS_HARD;
         end else if (want == TIER_CATCH) begin
            why = RS_CATCHUP;
         end else if (want == TIER_NORMAL) begin
            why = RS_LOST;
         end else begin
            why = (tier_state == TIER_CRUMB) ? RS_RESTORED : RS_RECEIVED;
         end
         tier_state = want;
         dwell_ms = '0;
         reason_state = why;
         report.changed = 1'b1;
      end
      report.tier = tier_state;
      report.reason = reason_state;
      tier_reports_q.push_back(report);
   endfunction

   function automatic req_type make_tick(input logic obstacle, input logic [DIST_W-1:0] gap,
                                         input logic [DIST_W-1:0] base,
                                         input logic [MS_W-1:0] loss, input logic fresh,
                                         input logic alive, input logic [TICK_W-1:0] tick);
      req_type it;
      it.obstacle_present = obstacle;
      it.gap_cm = gap;
      it.base_distance_cm = base;
      it.loss_time_ms = loss;
      it.prediction_fresh = fresh;
      it.link_alive = alive;
      it.tick_ms = tick;
      return it;
   endfunction

   function automatic req_type random_tick();
      req_type    it;
      longint     ratio;
      longint     edge_gap;
      longint     loss;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         it.base_distance_cm = '0;
      end else if (pick <= 2) begin
         it.base_distance_cm = DIST_W'($urandom);
      end else begin
         it.base_distance_cm = DIST_W'($urandom_range(1, 400));
      end

      pick = $urandom_range(0, 5);
      if (pick == 0) begin
         it.gap_cm = DIST_W'($urandom);
      end else if (pick == 1) begin
         it.gap_cm = DIST_W'($urandom_range(0, 2 * it.base_distance_cm));
      end else begin
         case ($urandom_range(0, 2))
            0: ratio = longint'(tier_cfg.chase_q8);
            1: ratio = longint'(tier_cfg.sprint_q8);
            default: ratio = longint'(tier_cfg.trail_q8);
         endcase
         if ($urandom_range(0, 1) == 1) begin
            ratio = ratio - longint'(tier_cfg.hyst_q8);
         end
         edge_gap = (longint'(it.base_distance_cm) * ratio) / 256 +
                    longint'($urandom_range(0, 4)) - 2;
         if (edge_gap < 0) begin
            edge_gap = 0;
         end else if (edge_gap > 65535) begin
            edge_gap = 65535;
         end
         it.gap_cm = DIST_W'(edge_gap);
      end

      pick = $urandom_range(0, 5);
      if (pick == 0) begin
         it.loss_time_ms = $urandom;
      end else if (pick == 1) begin
         loss = longint'(tier_cfg.link_timeout_ms) + longint'($urandom_range(0, 2)) - 1;
         if (loss < 0) begin
            loss = 0;
         end else if (loss > 64'hFFFF_FFFF) begin
            loss = 64'hFFFF_FFFF;
         end
         it.loss_time_ms = MS_W'(loss);
      end else begin
         it.loss_time_ms = $urandom_range(0, tier_cfg.link_timeout_ms);
      end

      it.obstacle_present = ($urandom_range(0, 7) == 0);
      it.prediction_fresh = 1'($urandom_range(0, 1));
      it.link_alive = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
         it.tick_ms = '0;
      end else if (pick < 7) begin
         it.tick_ms = TICK_MAX;
      end else if (pick < 10) begin
         it.tick_ms = TICK_W'($urandom);
      end else begin
         it.tick_ms = TICK_W'($urandom_range(1, 200));
      end
      return it;
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_HYSTERESIS:   tier_cfg.hyst_q8 = value[RATIO_W-1:0];
         CSR_CHASE:        tier_cfg.chase_q8 = value[RATIO_W-1:0];
         CSR_HARD_CATCH:   tier_cfg.sprint_q8 = value[RATIO_W-1:0];
         CSR_BREADCRUMB:   tier_cfg.trail_q8 = value[RATIO_W-1:0];
         CSR_COMM_TIMEOUT: tier_cfg.link_timeout_ms = value;
         CSR_REROUTE_MIN:  tier_cfg.reroute_min_dwell_ms = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] hysteresis,
                                 input logic [CSR_DATA_W-1:0] chase,
                                 input logic [CSR_DATA_W-1:0] hard_catch,
                                 input logic [CSR_DATA_W-1:0] breadcrumb,
                                 input logic [CSR_DATA_W-1:0] timeout_ms,
                                 input logic [CSR_DATA_W-1:0] min_dwell_ms);
      write_csr(CSR_HYSTERESIS, hysteresis);
      write_csr(CSR_CHASE, chase);
      write_csr(CSR_HARD_CATCH, hard_catch);
      write_csr(CSR_BREADCRUMB, breadcrumb);
      write_csr(CSR_COMM_TIMEOUT, timeout_ms);
      write_csr(CSR_REROUTE_MIN, min_dwell_ms);
      write_csr(CSR_SPARE_LO, $urandom);
      write_csr(CSR_SPARE_HI, $urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain_ticks();
      @(negedge clock);
      while (pending_ticks_q.size() != 0 || req_if.valid || tier_reports_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic queue_random_ticks(input int unsigned count);
      repeat (count) begin
         pending_ticks_q.push_back(random_tick());
      end
   endtask

   always @(posedge clock) begin : tick_driver
      req_type next_tick;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.obstacle_present <= 1'b0;
         req_if.gap_cm <= '0;
         req_if.base_distance_cm <= '0;
         req_if.loss_time_ms <= '0;
         req_if.prediction_fresh <= 1'b0;
         req_if.link_alive <= 1'b0;
         req_if.tick_ms <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left != 0 || pending_ticks_q.size() == 0) begin
            req_if.valid <= 1'b0;
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
            end
         end else begin
            next_tick = pending_ticks_q.pop_front();
            req_if.valid <= 1'b1;
            req_if.obstacle_present <= next_tick.obstacle_present;
            req_if.gap_cm <= next_tick.gap_cm;
            req_if.base_distance_cm <= next_tick.base_distance_cm;
            req_if.loss_time_ms <= next_tick.loss_time_ms;
            req_if.prediction_fresh <= next_tick.prediction_fresh;
            req_if.link_alive <= next_tick.link_alive;
            req_if.tick_ms <= next_tick.tick_ms;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(16, 128);
         end else begin
            stall_span <= stall_span - 1;
         end
         case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_if.ready <= (stall_phase[2:0] < 3'd5);
            default: rsp_if.ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   always @(posedge clock) begin : tier_monitor
      tier_report_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            predict_tier(make_tick(req_if.obstacle_present, req_if.gap_cm,
                                   req_if.base_distance_cm, req_if.loss_time_ms,
                                   req_if.prediction_fresh, req_if.link_alive,
                                   req_if.tick_ms));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (tier_reports_q.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) begin
                  $display("tier report with none pending: changed=%0d tier=%0d reason=%0d",
                           rsp_if.changed, rsp_if.tier_now, rsp_if.reason_code);
               end
            end else begin
               want = tier_reports_q.pop_front();
               if (rsp_if.changed !== want.changed || rsp_if.tier_now !== want.tier ||
                   rsp_if.reason_code !== want.reason) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10) begin
                     $display({"tier report mismatch: expected changed=%0d tier=%0d ",
                               "reason=%0d, got changed=%0d tier=%0d reason=%0d"},
                              want.changed, want.tier, want.reason, rsp_if.changed,
                              rsp_if.tier_now, rsp_if.reason_code);
                  end
               end
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Walk through every tier and reason at the reset register values.
      pending_ticks_q.push_back(make_tick(0, 0, 100, 0, 0, 1, 1));
      pending_ticks_q.push_back(make_tick(0, 0, 100, 0, 1, 1, 1));
      pending_ticks_q.push_back(make_tick(0, 151, 100, 0, 1, 1, 1));
      pending_ticks_q.push_back(make_tick(0, 145, 100, 0, 1, 1, 1));
      pending_ticks_q.push_back(make_tick(0, 139, 100, 0, 0, 1, 1));
      pending_ticks_q.push_back(make_tick(0, 201, 100, 0, 0, 1, 1));
      pending_ticks_q.push_back(make_tick(0, 401, 100, 0, 0, 1, 1));
      pending_ticks_q.push_back(make_tick(0, 395, 100, 0, 0, 1, 1));
      pending_ticks_q.push_back(make_tick(0, 0, 100, 0, 1, 1, 1));
      pending_ticks_q.push_back(make_tick(0, 0, 100, 0, 0, 0, 1));
      pending_ticks_q.push_back(make_tick(0, 0, 100, 0, 0, 1, 1));
      pending_ticks_q.push_back(make_tick(0, 0, 100, 60001, 0, 1, 1));
      pending_ticks_q.push_back(make_tick(0, 0, 100, 60000, 0, 1, 1));
      pending_ticks_q.push_back(make_tick(1, 0, 100, 0, 0, 1, 0));
      pending_ticks_q.push_back(make_tick(0, 0, 100, 0, 1, 1, 0));
      pending_ticks_q.push_back(make_tick(0, 0, 100, 0, 1, 1, 899));
      pending_ticks_q.push_back(make_tick(0, 0, 100, 0, 1, 1, 1));
      pending_ticks_q.push_back(make_tick(0, 0, 100, 0, 1, 1, 1));
      pending_ticks_q.push_back(make_tick(1, '1, '1, '1, 1, 1, TICK_MAX));
      pending_ticks_q.push_back(make_tick(1, '1, '1, '1, 1, 1, TICK_MAX));
      pending_ticks_q.push_back(make_tick(0, '1, 0, 0, 1, 1, 1));
      pending_ticks_q.push_back(make_tick(0, 0, 0, 0, 1, 1, 1));
      pending_ticks_q.push_back(make_tick(0, '1, '1, 0, 1, 1, 1));
      queue_random_ticks(130);
      drain_ticks();

      // Hysteresis above every ratio makes the current tier's threshold negative; the others are zero.
      apply_settings(32'd4095, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      queue_random_ticks(100);
      drain_ticks();

      apply_settings(32'd0, 32'd4095, 32'd4095, 32'd4095, '1, 32'd0);
      queue_random_ticks(100);
      drain_ticks();

      apply_settings($urandom_range(0, 128), $urandom_range(256, 640),
                     $urandom_range(400, 900), $urandom_range(800, 2048),
                     $urandom_range(0, 200000), $urandom_range(0, 3000));
      queue_random_ticks(110);
      drain_ticks();

      apply_settings($urandom, $urandom, $urandom, $urandom,
                     $urandom_range(0, 1000000), $urandom_range(0, 5000));
      queue_random_ticks(110);
      drain_ticks();

      // An unreachable reroute dwell keeps the tier held in reroute.
      apply_settings(CSR_DATA_W'(RST_HYSTERESIS), CSR_DATA_W'(RST_CHASE),
                     CSR_DATA_W'(RST_HARD_CATCH), CSR_DATA_W'(RST_BREADCRUMB),
                     RST_COMM_TIMEOUT, '1);
      pending_ticks_q.push_back(make_tick(1, 0, 100, 0, 1, 1, TICK_MAX));
      repeat (40) begin
         pending_ticks_q.push_back(random_tick());
         pending_ticks_q[$].obstacle_present = 1'b0;
         pending_ticks_q[$].tick_ms = TICK_MAX;
      end
      drain_ticks();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && tier_reports_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
